@@ design/blct_pkg.sv @@
// Shared constants, types and helpers for the Bresenham line cell tracer.
// No dependencies; every other file takes names from here by scope.
package blct_pkg;

  localparam int PIX_W       = 10;
  localparam int CELL_PIXELS = 16;
  localparam int GRID_DIM    = 64;
  localparam int MAX_CELLS   = 64;
  localparam int OUT_W       = 6;

  // grid coordinate width after the pixel-to-cell divide
  localparam int CW    = $clog2(((1 << PIX_W) - 1) / CELL_PIXELS + 1) < 1 ? 1 :
                         $clog2(((1 << PIX_W) - 1) / CELL_PIXELS + 1);
  localparam int ERR_W = CW + 3;
  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CW-1:0]    coord_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture endpoints as grid cells
    logic setup;  // derive deltas, error, step count
    logic step;   // advance one major-axis step
    logic flush;  // hand the held cell out as the last one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;  // current step is the final one
    logic cell_in;    // current cell will be kept
    logic pend_v;     // a cell is held back for last-flag lookahead
    logic slot_free;  // output register can take a word this cycle
  } sts_t;

  function automatic coord_t to_cell(input pix_t p);
    pix_t q;
    q = pix_t'(p / CELL_PIXELS);
    return q[CW-1:0];
  endfunction

endpackage

@@ design/blct_line_if.sv @@
// Line request channel: valid/ready plus two pixel endpoints.
// Depends on blct_pkg.
interface blct_line_if;
  logic           valid;
  logic           ready;
  blct_pkg::pix_t start_x;
  blct_pkg::pix_t start_y;
  blct_pkg::pix_t end_x;
  blct_pkg::pix_t end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ design/blct_cell_if.sv @@
// Traced cell channel: valid/ready plus one grid cell word.
// Depends on blct_pkg.
interface blct_cell_if;
  logic                        valid;
  logic                        ready;
  logic [blct_pkg::OUT_W-1:0]  cell_col;
  logic [blct_pkg::OUT_W-1:0]  cell_row;
  logic [blct_pkg::OUT_W-1:0]  step_index;
  logic                        last_cell;

  modport source (output valid, cell_col, cell_row, step_index, last_cell, input ready);
  modport sink   (input valid, cell_col, cell_row, step_index, last_cell, output ready);
endinterface

@@ design/blct_ctrl.sv @@
// Sequencer for the cell tracer: accept, setup, walk, flush.
// Depends on blct_pkg.
module blct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  blct_pkg::sts_t    sts_i,
  output blct_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       step_ok;

  // a kept cell pushes the held one out, which needs the output slot
  assign step_ok = !(sts_i.cell_in && sts_i.pend_v) || sts_i.slot_free;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (step_ok) begin
          cmd_o.step = 1'b1;
          if (sts_i.walk_last) state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_v) begin
          state_d = S_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/blct_dp.sv @@
// Datapath: grid conversion, Bresenham stepping, held cell and output word.
// Depends on blct_pkg.
module blct_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  blct_pkg::cmd_t              cmd_i,
  output blct_pkg::sts_t              sts_o,
  input  blct_pkg::pix_t              start_x_i,
  input  blct_pkg::pix_t              start_y_i,
  input  blct_pkg::pix_t              end_x_i,
  input  blct_pkg::pix_t              end_y_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [blct_pkg::OUT_W-1:0]  cell_col_o,
  output logic [blct_pkg::OUT_W-1:0]  cell_row_o,
  output logic [blct_pkg::OUT_W-1:0]  step_index_o,
  output logic                        last_cell_o
);

  blct_pkg::coord_t c0_q, r0_q, c1_q, r1_q;
  blct_pkg::coord_t col_q, row_q, major_q, minor_q, rem_q;
  blct_pkg::coord_t dx, dy;
  logic             xmaj_q, sxn_q, syn_q;
  blct_pkg::err_t   err_q, err_d, two_maj, two_min;
  blct_pkg::cnt_t   cnt_q;
  logic             pend_v_q, out_v_q;
  logic [blct_pkg::OUT_W-1:0] pend_col_q, pend_row_q, pend_idx_q;
  logic             cell_in, slot_free, move_minor, push;

  assign dx = (c1_q >= c0_q) ? c1_q - c0_q : c0_q - c1_q;
  assign dy = (r1_q >= r0_q) ? r1_q - r0_q : r0_q - r1_q;

  assign two_maj = blct_pkg::err_t'({major_q, 1'b0});
  assign two_min = blct_pkg::err_t'({minor_q, 1'b0});
  assign move_minor = !err_q[blct_pkg::ERR_W-1];
  assign err_d = err_q - (move_minor ? two_maj : '0) + two_min;

  assign cell_in = (32'(col_q) < blct_pkg::GRID_DIM) &&
                   (32'(row_q) < blct_pkg::GRID_DIM) &&
                   (32'(cnt_q) < blct_pkg::MAX_CELLS);
  assign slot_free = !out_v_q || out_ready_i;
  assign push      = cmd_i.step && cell_in && pend_v_q;

  assign sts_o.walk_last = (rem_q == '0);
  assign sts_o.cell_in   = cell_in;
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.slot_free = slot_free;

  // stepping registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c0_q <= blct_pkg::to_cell(start_x_i);
      r0_q <= blct_pkg::to_cell(start_y_i);
      c1_q <= blct_pkg::to_cell(end_x_i);
      r1_q <= blct_pkg::to_cell(end_y_i);
    end
    if (cmd_i.setup) begin
      col_q   <= c0_q;
      row_q   <= r0_q;
      sxn_q   <= c1_q < c0_q;
      syn_q   <= r1_q < r0_q;
      xmaj_q  <= dx >= dy;
      major_q <= (dx >= dy) ? dx : dy;
      minor_q <= (dx >= dy) ? dy : dx;
      rem_q   <= (dx >= dy) ? dx : dy;
      err_q   <= blct_pkg::err_t'({((dx >= dy) ? dy : dx), 1'b0})
               - blct_pkg::err_t'((dx >= dy) ? dx : dy);
    end
    if (cmd_i.step) begin
      err_q <= err_d;
      rem_q <= rem_q - 1'b1;
      if (xmaj_q) begin
        col_q <= sxn_q ? col_q - 1'b1 : col_q + 1'b1;
        if (move_minor) row_q <= syn_q ? row_q - 1'b1 : row_q + 1'b1;
      end else begin
        row_q <= syn_q ? row_q - 1'b1 : row_q + 1'b1;
        if (move_minor) col_q <= sxn_q ? col_q - 1'b1 : col_q + 1'b1;
      end
      if (cell_in) begin
        pend_col_q <= blct_pkg::OUT_W'(col_q);
        pend_row_q <= blct_pkg::OUT_W'(row_q);
        pend_idx_q <= blct_pkg::OUT_W'(cnt_q);
      end
    end
  end

  // output word; no payload reset
  always_ff @(posedge clk_i) begin
    if (push || cmd_i.flush) begin
      cell_col_o   <= pend_col_q;
      cell_row_o   <= pend_row_q;
      step_index_o <= pend_idx_q;
      last_cell_o  <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.setup) begin
        cnt_q    <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.step && cell_in) begin
        cnt_q    <= cnt_q + 1'b1;
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (push || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;

endmodule

@@ design/bresenham_line_cell_trace_unit.sv @@
// Top level of the Bresenham line cell tracer: controller plus datapath.
// Depends on blct_pkg, blct_line_if, blct_cell_if, blct_ctrl, blct_dp.
//
//   port     dir   word                                       handshake
//   line_i   in    start_x, start_y, end_x, end_y (10b each)  valid/ready
//   cell_o   out   cell_col, cell_row, step_index, last_cell  valid/ready
//
// One line at a time. A line of N major-axis steps runs through accept,
// setup, N + 1 walk steps and one flush of the final cell.
// The walk loop advances the error/coordinate registers one step per
// cycle while the output does not stall it.
// Each kept cell is held one step so the last one can be flagged; a full
// output register with ready low stalls the walk. Reset clears state only.
module bresenham_line_cell_trace_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  blct_line_if.sink    line_i,
  blct_cell_if.source  cell_o
);

  blct_pkg::cmd_t cmd;
  blct_pkg::sts_t sts;

  // sequencer: owns the input handshake and all step/flush decisions
  blct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (line_i.valid),
    .in_ready_o (line_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: error stepping, lookahead cell and the output word register
  blct_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_x_i    (line_i.start_x),
    .start_y_i    (line_i.start_y),
    .end_x_i      (line_i.end_x),
    .end_y_i      (line_i.end_y),
    .out_ready_i  (cell_o.ready),
    .out_valid_o  (cell_o.valid),
    .cell_col_o   (cell_o.cell_col),
    .cell_row_o   (cell_o.cell_row),
    .step_index_o (cell_o.step_index),
    .last_cell_o  (cell_o.last_cell)
  );

endmodule
